FILE: rtl/fol_pkg.sv
// Shared constants, codes and controller command type for the frequency-ordered lookup table.
// No dependencies; every other rtl file refers to this package by scoped names.

package fol_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 16;
    localparam int COUNT_BITS  = 16;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

    // port field widths (fixed by the interface)
    localparam int IN_KEY_W    = 16;
    localparam int OUT_STAT_W  = 2;
    localparam int OUT_POS_W   = 4;
    localparam int OUT_CNT_W   = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_FIELDS_W  = OUT_STAT_W + OUT_POS_W + OUT_CNT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_LOCATE = 1'b1;

    localparam logic [OUT_STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [OUT_STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [OUT_STAT_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic load;    // latch the incoming request
        logic find;    // search the table, register match and bumped count
        logic update;  // reorder or append, load the result register
    } fol_cmd_t;

endpackage

FILE: rtl/frequency_ordered_lookup_table_core.sv
// Frequency-ordered lookup table: keys with access counts, kept in non-increasing count order.
// Input channel s_*: tuser = req_type (0 append at tail, 1 locate and bump), tdata = key.
// Result channel m_*: tdata = status, position, hit_count; one result per request.
// Status: 0 done or found, 1 key not found, 2 table full on append.
// A request is latched on acceptance and searched across all cells in parallel in the next
// cycle; the table is reordered (or the tail written) in the update step, which also loads
// the result register once the output register is free.
// The next request can be taken in the update step but not during a search, since
// the search of each request needs the table left by the one before.
// While the receiver stalls, the held result stays on m_tdata; a request already latched, or
// one taken while idle, finishes its search and waits in the update step, taking no other.
// Reset (aresetn low, synchronous) empties the table, clears all counts and drops m_tvalid.
// Depends on fol_pkg, fol_ctrl and fol_datapath.

module frequency_ordered_lookup_table_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fol_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] key
    input  logic                            s_tuser,   // [0] req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fol_pkg::M_TDATA_W-1:0]   m_tdata    // [1:0] status, [5:2] position,
                                                       // [21:6] hit_count, rest zero
);

    fol_pkg::fol_cmd_t cmd;
    logic [fol_pkg::OUT_STAT_W-1:0] status;
    logic [fol_pkg::OUT_POS_W-1:0]  position;
    logic [fol_pkg::OUT_CNT_W-1:0]  hit_count;

    fol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fol_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_req_type   (s_tuser),
        .in_key        (s_tdata),
        .out_status    (status),
        .out_position  (position),
        .out_hit_count (hit_count)
    );

    assign m_tdata = fol_pkg::M_TDATA_W'({hit_count, position, status});

endmodule

FILE: rtl/fol_ctrl.sv
// Request sequencer for the frequency-ordered lookup table: accept, search, update.
// Depends on fol_pkg; drives the datapath through fol_pkg::fol_cmd_t.

module fol_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output fol_pkg::fol_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FIND   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;
    // a new request may be latched in the same cycle the table is updated
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_UPDATE) && out_free);
    assign m_tvalid = m_valid_reg;

    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.find   = (state_reg == S_FIND);
    assign cmd.update = (state_reg == S_UPDATE) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.load) state_next = S_FIND;
            end
            S_FIND: begin
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) state_next = cmd.load ? S_FIND : S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.update) m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/fol_datapath.sv
// Table cells, parallel key search, count-ordered move and result register.
// Depends on fol_pkg; sequenced by fol_ctrl through fol_pkg::fol_cmd_t.

module fol_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fol_pkg::fol_cmd_t                cmd,
    input  logic                             in_req_type,
    input  logic [fol_pkg::IN_KEY_W-1:0]     in_key,
    output logic [fol_pkg::OUT_STAT_W-1:0]   out_status,
    output logic [fol_pkg::OUT_POS_W-1:0]    out_position,
    output logic [fol_pkg::OUT_CNT_W-1:0]    out_hit_count
);

    localparam int DEPTH = fol_pkg::TABLE_DEPTH;
    localparam int KW    = fol_pkg::KEY_BITS;
    localparam int CW    = fol_pkg::COUNT_BITS;
    localparam int IW    = fol_pkg::IDX_W;
    localparam int FW    = fol_pkg::FILL_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    logic [KW-1:0] key_cell_reg [DEPTH];
    logic [CW-1:0] cnt_cell_reg [DEPTH];
    logic [FW-1:0] fill_reg;

    logic          req_type_reg;
    logic [KW-1:0] key_reg;
    logic          hit_reg;
    logic [IW-1:0] match_reg;
    logic [CW-1:0] new_cnt_reg;

    logic [fol_pkg::OUT_STAT_W-1:0] status_reg;
    logic [fol_pkg::OUT_POS_W-1:0]  position_reg;
    logic [fol_pkg::OUT_CNT_W-1:0]  hit_count_reg;

    logic [KW-1:0]  key_masked;
    logic [63:0]    key_wide;
    logic [DEPTH-1:0] eq_vec, lower_vec;
    logic           hit_next;
    logic [IW-1:0]  match_next;
    logic [CW-1:0]  old_cnt;
    logic [IW-1:0]  dest;
    logic           full;
    logic [IW-1:0]  tail_idx;

    assign key_wide   = 64'(in_key);
    assign key_masked = key_wide[KW-1:0];
    assign full       = (fill_reg >= FW'(DEPTH));
    assign tail_idx   = fill_reg[IW-1:0];

    function automatic logic [fol_pkg::OUT_POS_W-1:0] to_pos(input logic [IW-1:0] idx);
        logic [31:0] t;
        t = 32'(idx);
        return t[fol_pkg::OUT_POS_W-1:0];
    endfunction

    function automatic logic [fol_pkg::OUT_CNT_W-1:0] to_cnt(input logic [CW-1:0] c);
        logic [31:0] t;
        t = 32'(c);
        return t[fol_pkg::OUT_CNT_W-1:0];
    endfunction

    // search: per-cell compare over the filled slots, first match wins
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            eq_vec[i] = (FW'(i) < fill_reg) && (key_cell_reg[i] == key_reg);
        end
        hit_next   = |eq_vec;
        match_next = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (eq_vec[i]) match_next = IW'(i);
        end
    end

    assign old_cnt = cnt_cell_reg[match_next];

    // move: entry goes in front of the first slot ahead of it with a lower count
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            lower_vec[i] = (IW'(i) < match_reg) && (cnt_cell_reg[i] < new_cnt_reg);
        end
        dest = match_reg;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (lower_vec[i]) dest = IW'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_type_reg <= in_req_type;
            key_reg      <= key_masked;
        end
        if (cmd.find) begin
            hit_reg     <= hit_next;
            match_reg   <= match_next;
            new_cnt_reg <= (old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1;
        end
        if (cmd.update) begin
            if (req_type_reg == fol_pkg::REQ_APPEND) begin
                status_reg    <= full ? fol_pkg::ST_FULL : fol_pkg::ST_OK;
                position_reg  <= full ? '0 : to_pos(tail_idx);
                hit_count_reg <= '0;
            end else if (hit_reg) begin
                status_reg    <= fol_pkg::ST_OK;
                position_reg  <= to_pos(dest);
                hit_count_reg <= to_cnt(new_cnt_reg);
            end else begin
                status_reg    <= fol_pkg::ST_NOT_FOUND;
                position_reg  <= '0;
                hit_count_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.update && (req_type_reg == fol_pkg::REQ_APPEND) && !full) begin
            fill_reg <= fill_reg + 1'b1;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic take_new, take_prev, take_tail;

        assign take_tail = cmd.update && (req_type_reg == fol_pkg::REQ_APPEND) && !full
                           && (tail_idx == IW'(g));
        assign take_new  = cmd.update && (req_type_reg == fol_pkg::REQ_LOCATE) && hit_reg
                           && (dest == IW'(g));
        if (g > 0) begin : g_shift
            assign take_prev = cmd.update && (req_type_reg == fol_pkg::REQ_LOCATE) && hit_reg
                               && (IW'(g) > dest) && (IW'(g) <= match_reg);
        end else begin : g_front
            assign take_prev = 1'b0;
        end

        always_ff @(posedge aclk) begin
            if (take_tail || take_new) begin
                key_cell_reg[g] <= key_reg;
            end else if (take_prev) begin
                key_cell_reg[g] <= key_cell_reg[(g > 0) ? g - 1 : 0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cnt_cell_reg[g] <= '0;
            end else if (take_tail) begin
                cnt_cell_reg[g] <= '0;
            end else if (take_new) begin
                cnt_cell_reg[g] <= new_cnt_reg;
            end else if (take_prev) begin
                cnt_cell_reg[g] <= cnt_cell_reg[(g > 0) ? g - 1 : 0];
            end
        end
    end

    assign out_status    = status_reg;
    assign out_position  = position_reg;
    assign out_hit_count = hit_count_reg;

endmodule

FILE: rtl/fol_checker.sv
// Port-level checks for frequency_ordered_lookup_table_core, bound to the top level.
// Depends on fol_pkg for the status codes.

module fol_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fol_pkg::M_TDATA_W-1:0] m_tdata
);

    // a held result must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // after a transaction the block is busy searching and takes no request in the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken during search");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == fol_pkg::ST_OK) || (m_tdata[1:0] == fol_pkg::ST_NOT_FOUND)
                     || (m_tdata[1:0] == fol_pkg::ST_FULL))
        else $error("bad status code");

    // miss and full results carry zero position and count
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != fol_pkg::ST_OK) |-> (m_tdata[21:2] == '0))
        else $error("failed request with nonzero fields");

    // a new result must be preceded by a search, during which s_tready is low
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid ##1 m_tvalid |-> $past(!s_tready, 2))
        else $error("result appeared without a search");

endmodule

bind frequency_ordered_lookup_table_core fol_checker u_fol_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/tb.sv
// Self-checking testbench for frequency_ordered_lookup_table_core.
// Keeps its own copy of the key/count table and checks each result against it or a fixed expected result.
// Depends on rtl/fol_pkg.sv and rtl/frequency_ordered_lookup_table_core.sv.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT  = 100_000;
    localparam int N_RANDOM     = 700;
    localparam int N_HOT        = 25;
    localparam int DRAIN_CYCLES = 10;

    // field order matches m_tdata from bit 0 up: status, position, hit_count
    typedef struct packed {
        logic [fol_pkg::OUT_CNT_W-1:0]  hit_count;
        logic [fol_pkg::OUT_POS_W-1:0]  position;
        logic [fol_pkg::OUT_STAT_W-1:0] status;
    } lut_result_t;

    typedef struct packed {
        logic                         req;
        logic [fol_pkg::KEY_BITS-1:0] key;
        logic                         typed;
        lut_result_t                  want;
    } stim_row_t;

    localparam int N_DIRECTED = 24;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{fol_pkg::REQ_LOCATE, 16'h1234, 1'b1,
          '{16'd0, 4'd0, fol_pkg::ST_NOT_FOUND}},                              // empty table
        '{fol_pkg::REQ_APPEND, 16'h0000, 1'b1, '{16'd0, 4'd0, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'hFFFF, 1'b1, '{16'd0, 4'd1, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'hA5A5, 1'b1, '{16'd0, 4'd2, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'hFFFF, 1'b1, '{16'd0, 4'd3, fol_pkg::ST_OK}}, // duplicate
        '{fol_pkg::REQ_LOCATE, 16'hFFFF, 1'b0, '{16'd0, 4'd0, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_LOCATE, 16'hFFFF, 1'b0, '{16'd0, 4'd0, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_LOCATE, 16'hA5A5, 1'b0, '{16'd0, 4'd0, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_LOCATE, 16'h0000, 1'b0, '{16'd0, 4'd0, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_LOCATE, 16'h5A5A, 1'b1, '{16'd0, 4'd0, fol_pkg::ST_NOT_FOUND}},
        '{fol_pkg::REQ_APPEND, 16'h8000, 1'b1, '{16'd0, 4'd4, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'h0001, 1'b1, '{16'd0, 4'd5, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'h00FF, 1'b1, '{16'd0, 4'd6, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'hFF00, 1'b1, '{16'd0, 4'd7, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'h1234, 1'b1, '{16'd0, 4'd8, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'h4321, 1'b1, '{16'd0, 4'd9, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'hBEEF, 1'b1, '{16'd0, 4'd10, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'hCAFE, 1'b1, '{16'd0, 4'd11, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'h0F0F, 1'b1, '{16'd0, 4'd12, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'hF0F0, 1'b1, '{16'd0, 4'd13, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'h3C3C, 1'b1, '{16'd0, 4'd14, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'h5555, 1'b1, '{16'd0, 4'd15, fol_pkg::ST_OK}},
        '{fol_pkg::REQ_APPEND, 16'h7777, 1'b1, '{16'd0, 4'd0, fol_pkg::ST_FULL}}, // full
        '{fol_pkg::REQ_LOCATE, 16'h5555, 1'b0, '{16'd0, 4'd0, fol_pkg::ST_OK}}
    };

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [fol_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = fol_pkg::REQ_APPEND;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [fol_pkg::M_TDATA_W-1:0] m_tdata;

    // mirror of the table contents
    logic [fol_pkg::KEY_BITS-1:0]   tbl_key [fol_pkg::TABLE_DEPTH];
    logic [fol_pkg::COUNT_BITS-1:0] tbl_cnt [fol_pkg::TABLE_DEPTH];
    int                             tbl_fill;

    lut_result_t pending_results [$];
    int  err_cnt    = 0;
    int  cycles     = 0;
    int  burst_left = 0;
    int  rx_left    = 0;
    int  rx_mode    = 0;
    bit  steady     = 1'b0;
    int  n_ok       = 0;
    int  n_miss     = 0;
    int  n_full     = 0;

    frequency_ordered_lookup_table_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Apply one request to the mirror table and return what the block should report.
    function automatic lut_result_t lookup_update(input logic req,
                                                  input logic [fol_pkg::KEY_BITS-1:0] key);
        lut_result_t                    r;
        int                             i;
        int                             j;
        bit                             hit;
        logic [fol_pkg::COUNT_BITS-1:0] c;
        r   = '{16'd0, 4'd0, fol_pkg::ST_NOT_FOUND};
        hit = 1'b0;
        j   = 0;
        if (req == fol_pkg::REQ_APPEND) begin
            if (tbl_fill >= fol_pkg::TABLE_DEPTH) begin
                r.status = fol_pkg::ST_FULL;
            end else begin
                tbl_key[tbl_fill] = key;
                tbl_cnt[tbl_fill] = '0;
                r = '{16'd0, tbl_fill[fol_pkg::OUT_POS_W-1:0], fol_pkg::ST_OK};
                tbl_fill++;
            end
        end else begin
            for (i = 0; i < tbl_fill && !hit; i++) begin
                if (tbl_key[i] == key) begin
                    hit = 1'b1;
                    j   = i;
                end
            end
            if (hit) begin
                c = tbl_cnt[j];
                if (c != {fol_pkg::COUNT_BITS{1'b1}})
                    c++;
                // move forward past strictly lower counts only
                while (j > 0 && tbl_cnt[j-1] < c) begin
                    tbl_key[j] = tbl_key[j-1];
                    tbl_cnt[j] = tbl_cnt[j-1];
                    j--;
                end
                tbl_key[j] = key;
                tbl_cnt[j] = c;
                r = '{c, j[fol_pkg::OUT_POS_W-1:0], fol_pkg::ST_OK};
            end
        end
        return r;
    endfunction

    // Drive one request, honoring the burst/gap pattern, and log its expected result.
    task automatic send_request(input logic req, input logic [fol_pkg::KEY_BITS-1:0] key,
                                input logic typed, input lut_result_t typed_want);
        int          gap;
        lut_result_t pred;
        gap = 0;
        if (!steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        pred = lookup_update(req, key);
        pending_results.push_back(typed ? typed_want : pred);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Receiver stall pattern: always ready, random stalls, or a periodic duty cycle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(20, 120);
            end
            rx_left--;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((rx_left % 5) >= 2);
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        lut_result_t got;
        lut_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[fol_pkg::M_FIELDS_W-1:0];
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing pending: m_tdata=%h", m_tdata);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    err_cnt++;
                end
                if (got.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, got.position);
                    err_cnt++;
                end
                if (got.hit_count !== want.hit_count) begin
                    $error("hit_count: expected %0d, got %0d", want.hit_count, got.hit_count);
                    err_cnt++;
                end
                case (want.status)
                    fol_pkg::ST_OK:        n_ok++;
                    fol_pkg::ST_NOT_FOUND: n_miss++;
                    default:               n_full++;
                endcase
            end
        end
    end

    initial begin : stimulus
        int                           k;
        int                           pick;
        logic                         req;
        logic [fol_pkg::KEY_BITS-1:0] key;
        logic [fol_pkg::KEY_BITS-1:0] hot_key;
        tbl_fill = 0;
        for (k = 0; k < fol_pkg::TABLE_DEPTH; k++) begin
            tbl_key[k] = '0;
            tbl_cnt[k] = '0;
        end
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++)
            send_request(DIRECTED[k].req, DIRECTED[k].key, DIRECTED[k].typed,
                         DIRECTED[k].want);

        // mostly hits on stored keys so entries keep moving; the rest misses and appends
        for (k = 0; k < N_RANDOM; k++) begin
            pick = $urandom_range(0, 99);
            key  = $urandom_range(0, 16'hFFFF);
            if (pick < 15) begin
                req = fol_pkg::REQ_APPEND;
            end else begin
                req = fol_pkg::REQ_LOCATE;
                if (pick >= 30 && tbl_fill > 0)
                    key = tbl_key[$urandom_range(0, tbl_fill - 1)];
            end
            send_request(req, key, 1'b0, '0);
        end

        // hammer two tail entries back to back with no stalls so they climb the table
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        steady = 1'b1;
        repeat (2) begin
            hot_key = tbl_key[tbl_fill - 1];
            repeat (N_HOT)
                send_request(fol_pkg::REQ_LOCATE, hot_key, 1'b0, '0);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d found/done, %0d not-found and %0d table-full transactions,",
                 n_ok, n_miss, n_full);
        $display("under random bursts and stalls, then a back-to-back run of repeated hits.");
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
